>>> design/rws_pkg.sv
`timescale 1ns / 1ps
package rws_pkg;

	localparam int IDX_W     = 12;
	localparam int LEN_W     = 13;
	localparam int STEP_W    = 32;
	localparam int K_W       = 13;
	localparam int ALPHA_W   = 32;
	localparam int BETA_W    = 34;
	localparam int PMAG_W    = 35;
	localparam int EXP_W     = 25;
	localparam int FRAC_W    = 17;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 1'd1;

	// 1.0 in Q.30
	localparam logic [PMAG_W-1:0] ONE_Q30 = PMAG_W'(36'h0_4000_0000);

	typedef struct packed {
		logic           kill;
		logic [K_W-1:0] k;
	} rws_fold_t;

	typedef struct packed {
		logic              kill;
		logic [BETA_W-1:0] beta;
	} rws_beta_t;

	typedef struct packed {
		logic              kill;
		logic              neg;
		logic [PMAG_W-1:0] pmag;
		logic [EXP_W-1:0]  e;
	} rws_exp_t;

	// exp(-m), Q.24
	function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] m);
		logic [EXP_W-1:0] v;
		unique case (m)
			4'd0:  v = 25'd16777216;
			4'd1:  v = 25'd6171993;
			4'd2:  v = 25'd2270549;
			4'd3:  v = 25'd835288;
			4'd4:  v = 25'd307285;
			4'd5:  v = 25'd113044;
			4'd6:  v = 25'd41587;
			4'd7:  v = 25'd15299;
			4'd8:  v = 25'd5628;
			4'd9:  v = 25'd2070;
			4'd10: v = 25'd762;
			4'd11: v = 25'd280;
			4'd12: v = 25'd103;
			4'd13: v = 25'd38;
			4'd14: v = 25'd14;
			4'd15: v = 25'd5;
		endcase
		return v;
	endfunction

	// exp(-j/16), Q.16
	function automatic logic [FRAC_W-1:0] exp_frac(input logic [4:0] j);
		logic [FRAC_W-1:0] v;
		unique case (j)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd61565;
			5'd2:  v = 17'd57835;
			5'd3:  v = 17'd54331;
			5'd4:  v = 17'd51039;
			5'd5:  v = 17'd47947;
			5'd6:  v = 17'd45042;
			5'd7:  v = 17'd42313;
			5'd8:  v = 17'd39750;
			5'd9:  v = 17'd37341;
			5'd10: v = 17'd35079;
			5'd11: v = 17'd32954;
			5'd12: v = 17'd30957;
			5'd13: v = 17'd29081;
			5'd14: v = 17'd27319;
			5'd15: v = 17'd25664;
			5'd16: v = 17'd24109;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> design/rws_index_if.sv
`timescale 1ns / 1ps
interface rws_index_if;
	import rws_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;

	modport source (output valid, output index, input ready);
	modport sink (input valid, input index, output ready);
endinterface

>>> design/rws_sample_if.sv
`timescale 1ns / 1ps
interface rws_sample_if;
	import rws_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

>>> design/rws_fold.sv
`timescale 1ns / 1ps
module rws_fold #(
	parameter int MAX_LEN = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rws_pkg::STEP_W-1:0]   phase_step,
	input  logic [rws_pkg::LEN_W-1:0]    length,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rws_pkg::IDX_W-1:0]    index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rws_pkg::rws_fold_t           out_data
);
	import rws_pkg::*;

	localparam int CW = 17;
	localparam logic [CW-1:0] MAX_LEN_V = CW'(MAX_LEN);

	logic [CW-1:0] len_raw, len_c, idx_w, half, k_back;
	logic          kill;
	logic [K_W-1:0] k;
	logic          v_s1;
	rws_fold_t     d_s1;
	logic          en_s1;

	always_comb begin
		len_raw = {{(CW-LEN_W){1'b0}}, length};
		len_c   = len_raw;
		if (len_raw == '0) begin
			len_c = CW'(1);
		end
		if (len_raw > MAX_LEN_V) begin
			len_c = MAX_LEN_V;
		end
		idx_w  = {{(CW-IDX_W){1'b0}}, index};
		half   = len_c >> 1;
		k_back = len_c - idx_w;
		// zero step: only index 0 survives, and k = 0 yields 1.0 by itself
		kill   = (idx_w >= len_c) || ((phase_step == '0) && (index != '0));
		k      = (idx_w <= half) ? K_W'(idx_w) : K_W'(k_back);
	end

	assign en_s1    = !v_s1 || out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			d_s1.kill <= kill;
			d_s1.k    <= k;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !d_s1.kill |-> d_s1.k <= K_W'(4096))
		else $error("folded index out of range");

endmodule

>>> design/rws_square.sv
`timescale 1ns / 1ps
module rws_square (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rws_pkg::STEP_W-1:0] phase_step,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rws_pkg::rws_fold_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output rws_pkg::rws_beta_t         out_data
);
	import rws_pkg::*;

	localparam int AF_W = STEP_W + K_W;

	logic [AF_W-1:0]      alpha_full;
	logic [2*ALPHA_W-1:0] sq;
	logic                 v_s2, v_s3, en_s2, en_s3;
	logic                 kill_s2;
	logic [ALPHA_W-1:0]   alpha_s2;
	rws_beta_t            d_s3;

	assign alpha_full = {{K_W{1'b0}}, phase_step} * {{STEP_W{1'b0}}, in_data.k};
	assign sq         = {{ALPHA_W{1'b0}}, alpha_s2} * {{ALPHA_W{1'b0}}, alpha_s2};

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) v_s2 <= in_valid;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			// alpha of 4.0 or more means beta >= 16
			kill_s2  <= in_data.kill || (|alpha_full[AF_W-1:ALPHA_W]);
			alpha_s2 <= alpha_full[ALPHA_W-1:0];
		end
		if (en_s3 && v_s2) begin
			d_s3.kill <= kill_s2;
			d_s3.beta <= sq[2*ALPHA_W-1:30];
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

>>> design/rws_exp.sv
`timescale 1ns / 1ps
module rws_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rws_pkg::rws_beta_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rws_pkg::rws_exp_t  out_data
);
	import rws_pkg::*;

	localparam int DIFF_W = 12;
	localparam int R_W    = 26;

	logic [3:0]              m, m_s4;
	logic [3:0]              j;
	logic [R_W-1:0]          r;
	logic [FRAC_W-1:0]       lo, hi, lo_s4, f;
	logic [DIFF_W-1:0]       diff, t_s4;
	logic [DIFF_W+R_W-1:0]   iprod;
	logic [PMAG_W-1:0]       two_b, pmag, pmag_s4;
	logic                    neg, neg_s4, kill_s4;
	logic [EXP_W+FRAC_W-1:0] eprod;
	logic                    v_s4, v_s5, en_s4, en_s5;
	rws_exp_t                d_s5;

	always_comb begin
		m     = in_data.beta[33:30];
		j     = in_data.beta[29:26];
		r     = in_data.beta[R_W-1:0];
		lo    = exp_frac({1'b0, j});
		hi    = exp_frac({1'b0, j} + 5'd1);
		diff  = DIFF_W'(lo - hi);
		iprod = {{R_W{1'b0}}, diff} * {{DIFF_W{1'b0}}, r};
		two_b = {in_data.beta, 1'b0};
		neg   = two_b > ONE_Q30;
		pmag  = neg ? (two_b - ONE_Q30) : (ONE_Q30 - two_b);
	end

	assign f     = lo_s4 - {{(FRAC_W-DIFF_W){1'b0}}, t_s4};
	assign eprod = {{FRAC_W{1'b0}}, exp_int(m_s4)} * {{EXP_W{1'b0}}, f};

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			kill_s4 <= in_data.kill;
			m_s4    <= m;
			lo_s4   <= lo;
			t_s4    <= iprod[DIFF_W+R_W-1:R_W];
			neg_s4  <= neg;
			pmag_s4 <= pmag;
		end
		if (en_s5 && v_s4) begin
			d_s5.kill <= kill_s4;
			d_s5.neg  <= neg_s4;
			d_s5.pmag <= pmag_s4;
			d_s5.e    <= eprod[EXP_W+16-1:16];
		end
	end

	assign out_valid = v_s5;
	assign out_data  = d_s5;

	a_e_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> d_s5.e <= EXP_W'(25'h100_0000))
		else $error("exp result above 1.0");

endmodule

>>> design/ricker_wavelet_sample.sv
// Ricker wavelet sample: (1 - 2*beta) * exp(-beta), beta = (step*k)^2, Q2.14 out.
// Throughput: one item per cycle while the sample sink is ready; six register
// stages, each stage holds its item only while the stage after it is stalled.
// Reset (arst_n low, async): all stages empty, phase_step = 0, length = 1.
`timescale 1ns / 1ps
module ricker_wavelet_sample #(
	parameter int MAX_LEN = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rws_pkg::CFG_DAT_W-1:0] cfg_data,
	rws_index_if.sink                     index_ch,
	rws_sample_if.source                  sample_ch
);
	import rws_pkg::*;

	localparam int PE_W  = PMAG_W + EXP_W;
	localparam int RND_B = 39;

	// Config registers; the user must write them only while the pipe is drained; the block does not enforce this.
	logic [STEP_W-1:0] phase_step_q;
	logic [LEN_W-1:0]  length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			length_q     <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_LENGTH:     length_q     <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// Stage 1: clamp length, fold index into k, flag dead items.
	logic      f_valid, f_ready;
	rws_fold_t f_data;

	rws_fold #(.MAX_LEN(MAX_LEN)) u_fold (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (phase_step_q),
		.length     (length_q),
		.in_valid   (index_ch.valid),
		.in_ready   (index_ch.ready),
		.index      (index_ch.index),
		.out_valid  (f_valid),
		.out_ready  (f_ready),
		.out_data   (f_data)
	);

	// Stages 2-3: alpha = step*k, beta = alpha^2 >> 30.
	logic      b_valid, b_ready;
	rws_beta_t b_data;

	rws_square u_square (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (phase_step_q),
		.in_valid   (f_valid),
		.in_ready   (f_ready),
		.in_data    (f_data),
		.out_valid  (b_valid),
		.out_ready  (b_ready),
		.out_data   (b_data)
	);

	// Stages 4-5: exp(-beta) by table + interpolation, and |1 - 2*beta|.
	logic     e_valid, e_ready;
	rws_exp_t e_data;

	rws_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_data   (b_data),
		.out_valid (e_valid),
		.out_ready (e_ready),
		.out_data  (e_data)
	);

	// Stage 6: final product, round half up on magnitude, apply sign.
	logic [PE_W-1:0]     pe;
	logic [SAMPLE_W-1:0] mag, res;
	logic                v_s6, en_s6;
	logic [SAMPLE_W-1:0] sample_s6;

	always_comb begin
		pe  = ({{EXP_W{1'b0}}, e_data.pmag} * {{PMAG_W{1'b0}}, e_data.e})
		      + (PE_W'(1) << RND_B);
		mag = pe[40+SAMPLE_W-1:40];
		res = e_data.neg ? (SAMPLE_W'(0) - mag) : mag;
		if (e_data.kill) begin
			res = '0;
		end
	end

	assign en_s6   = !v_s6 || sample_ch.ready;
	assign e_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= e_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && e_valid) begin
			sample_s6 <= res;
		end
	end

	assign sample_ch.valid  = v_s6;
	assign sample_ch.sample = $signed(sample_s6);

	// wavelet peak is 1.0; anything larger is an arithmetic slip
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.valid |-> ($signed(sample_ch.sample) <= 16'sd16384)
		&& ($signed(sample_ch.sample) >= -16'sd16384))
		else $error("sample outside +/-1.0");

	// input backs up only when every stage is full and the sink stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!index_ch.ready |-> sample_ch.valid && !sample_ch.ready && f_valid
		&& b_valid && e_valid)
		else $error("input stalled with a bubble in the pipe");

	// a killed item never leaves as nonzero
	a_kill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid && e_ready && e_data.kill |=> sample_ch.sample == '0)
		else $error("killed item gave nonzero sample");

endmodule

>>> bench/ricker_wavelet_sample_tb.sv
`timescale 1ns / 1ps
module ricker_wavelet_sample_tb;
	import rws_pkg::*;

	// Generous ceiling: ~1350 items, each with its worst-case idle gap, output
	// stall and pipeline delay, plus one long output hold per run and the drains.
	localparam int CYCLE_LIMIT = 300000;
	localparam int PIPE_DEPTH  = 6;
	localparam int HOLD_CYCLES = 80;
	localparam int TB_MAX_LEN  = 4096;

	// Tracks the block's two registers and the samples still owed by it.
	class wavelet_tracker;
		bit [STEP_W-1:0]            step_q30;
		bit [LEN_W-1:0]             buf_len;
		bit signed [SAMPLE_W-1:0]   expected_samples[$];
		int                         fail_count;
		longint unsigned            exp_whole_q24[16] = '{
			16777216, 6171993, 2270549, 835288, 307285, 113044, 41587, 15299,
			5628, 2070, 762, 280, 103, 38, 14, 5};
		longint unsigned            exp_sixteenth_q16[17] = '{
			65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
			39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};

		function new();
			step_q30   = '0;
			buf_len    = LEN_W'(1);
			fail_count = 0;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		function bit signed [SAMPLE_W-1:0] ricker_value(bit [IDX_W-1:0] idx);
			longint unsigned len, k, alpha, beta, m, j, r, lo, hi, f, e, pmag, mag;
			bit neg;
			len = 64'(buf_len);
			if (len == 0)
				len = 1;
			if (len > TB_MAX_LEN)
				len = TB_MAX_LEN;
			if (64'(idx) >= len)
				return '0;
			if (step_q30 == 0)
				return (idx == 0) ? 16'sd16384 : 16'sd0;
			// circular shift: the back half of the buffer is negative time
			k = (64'(idx) <= len / 2) ? 64'(idx) : len - 64'(idx);
			alpha = 64'(step_q30) * k;
			if (alpha >= (64'd4 << 30))
				return '0;
			beta = (alpha * alpha) >> 30;
			if (beta >= (64'd16 << 30))
				return '0;
			m  = (beta >> 30) & 64'd15;
			j  = (beta >> 26) & 64'd15;
			r  = beta & ((64'd1 << 26) - 1);
			lo = exp_sixteenth_q16[j];
			hi = exp_sixteenth_q16[j + 1];
			f  = lo - (((lo - hi) * r) >> 26);
			e  = (exp_whole_q24[m] * f) >> 16;
			if (2 * beta > (64'd1 << 30)) begin
				neg  = 1'b1;
				pmag = 2 * beta - (64'd1 << 30);
			end else begin
				neg  = 1'b0;
				pmag = (64'd1 << 30) - 2 * beta;
			end
			mag = (pmag * e + (64'd1 << 39)) >> 40;
			if (neg)
				mag = 64'd0 - mag;
			return SAMPLE_W'(mag);
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			fail_count++;
		endtask

		task note_index(bit [IDX_W-1:0] idx);
			expected_samples.push_back(ricker_value(idx));
		endtask

		task check_sample(logic signed [SAMPLE_W-1:0] got);
			bit signed [SAMPLE_W-1:0] want;
			if (expected_samples.size() == 0) begin
				report($sformatf("sample %0d with nothing outstanding", got));
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want)
				report($sformatf("sample got %0d want %0d", got, want));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	rws_index_if  index_ch ();
	rws_sample_if sample_ch ();

	ricker_wavelet_sample dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.index_ch  (index_ch),
		.sample_ch (sample_ch)
	);

	wavelet_tracker tracker = new();

	bit idle_on;     // random bursts of idling on both channels
	bit long_hold;   // one-shot request for a long output hold
	int cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a missing sample ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Both monitors sample at the edge, before this step's updates land.
	always @(posedge clk) begin
		if (arst_n && index_ch.valid && index_ch.ready)
			tracker.note_index(index_ch.index);
	end

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready)
			tracker.check_sample(sample_ch.sample);
	end

	// Output side. The long hold is counted here so it runs regardless of
	// what the sender is doing; the pipeline fills and index ready drops.
	initial begin
		int hold_left, stall_left;
		hold_left  = 0;
		stall_left = 0;
		sample_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				sample_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				sample_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				sample_ch.ready <= 1'b0;
			end else begin
				sample_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one index and hold it until taken; may idle first.
	task automatic send_index(input logic [IDX_W-1:0] idx);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			index_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		index_ch.valid <= 1'b1;
		index_ch.index <= idx;
		@(posedge clk);
		while (!index_ch.ready)
			@(posedge clk);
	endtask

	// Both registers back to back; only called with the pipeline empty.
	task automatic configure(input logic [STEP_W-1:0] step, input int len);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PHASE_STEP;
		cfg_data  <= CFG_DAT_W'(step);
		@(posedge clk);
		cfg_index <= REG_LENGTH;
		cfg_data  <= CFG_DAT_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.step_q30 = step;
		tracker.buf_len  = LEN_W'(len);
	endtask

	// Lower valid, wait for every owed sample, then let the pipe settle.
	task automatic drain();
		index_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	initial begin
		logic [STEP_W-1:0] step;
		int                len;
		int                sel;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_PHASE_STEP;
		cfg_data       = '0;
		index_ch.valid = 1'b0;
		index_ch.index = '0;
		idle_on        = 1'b1;
		long_hold      = 1'b0;
		cycle_count    = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: zero step, length 1 -> impulse, index past length
		send_index(12'd0);
		send_index(12'd4095);
		drain();

		// Zero step over the full buffer: impulse only at index 0
		configure('0, TB_MAX_LEN);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd2048);
		send_index(12'd4095);
		drain();

		// step = 1/64: beta crosses 1/2 near k=45, 1 at k=64, 16 at k=256;
		// back half of the buffer mirrors the front half
		configure(32'h0100_0000, TB_MAX_LEN);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd45);
		send_index(12'd64);
		send_index(12'd255);
		send_index(12'd256);
		send_index(12'd2048);
		send_index(12'd4095);
		send_index(12'd3840);
		send_index(12'd4000);
		drain();

		// Largest step: k=1 gives beta just under 16, k=2 overflows alpha
		configure(32'hFFFF_FFFF, 8);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd2);
		send_index(12'd4);
		send_index(12'd7);
		drain();

		// Smallest nonzero step, length 2, and index at length
		configure(32'd1, 2);
		send_index(12'd0);
		send_index(12'd1);
		send_index(12'd2);
		drain();

		// Random settings; mostly in-buffer indices, some past the end.
		// Phase 3 carries the long output hold, the last phase runs flat out.
		for (int phase = 0; phase < 10; phase++) begin
			sel = $urandom_range(0, 7);
			if (sel == 0)
				step = '0;
			else if (sel == 1)
				step = 32'hFFFF_FFFF;
			else
				step = $urandom >> $urandom_range(0, 31);
			sel = $urandom_range(0, 7);
			if (sel == 0)
				len = 1;
			else if (sel == 1)
				len = TB_MAX_LEN;
			else if (sel == 2)
				len = $urandom_range(1, 16);
			else
				len = $urandom_range(1, TB_MAX_LEN);
			configure(step, len);
			idle_on = (phase != 9);
			if (phase == 3)
				long_hold = 1'b1;
			for (int n = 0; n < 130; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_index(IDX_W'($urandom_range(0, 4095)));
				else
					send_index(IDX_W'($urandom_range(0, len - 1)));
			end
			drain();
		end

		if (tracker.fail_count == 0 && tracker.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
